[rtl/sme_pkg.sv]
// Shared types and constants of the stack-machine execute unit.
// Used by sme_cell, sme_stack and stack_machine_execute_unit_top. No dependencies.
`default_nettype none

package sme_pkg;

  localparam int StackDepth = 256;
  localparam int PcW        = 16;
  localparam int WordW      = 32;
  localparam int DepthW     = $clog2(StackDepth + 1);

  typedef logic [WordW-1:0]  word_t;
  typedef logic [DepthW-1:0] depth_t;
  typedef logic [PcW-1:0]    pc_t;

  // Instruction codes as they arrive on the mode field.
  typedef enum logic [3:0] {
    OP_PUSH    = 4'd0,
    OP_ADD     = 4'd1,
    OP_SUB     = 4'd2,
    OP_AND     = 4'd3,
    OP_OR      = 4'd4,
    OP_SWAP    = 4'd5,
    OP_DUP     = 4'd6,
    OP_POP     = 4'd7,
    OP_GOTO    = 4'd8,
    OP_IFEQ    = 4'd9,
    OP_IFLT    = 4'd10,
    OP_IFCMPEQ = 4'd11
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  // Movement of the whole stack; every cell follows the same command.
  typedef enum logic [2:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP1,
    STK_POP2,
    STK_REPL,
    STK_SWAP
  } stk_op_e;

  // Source of one cell's next value.
  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_UP,
    SEL_DN1,
    SEL_DN2
  } sel_e;

  typedef struct packed {
    stk_op_e op;
    word_t   top_in;
  } stk_cmd_t;

endpackage

`default_nettype wire

[rtl/stack_machine_execute_unit_top.sv]
// Top level of the stack-machine execute unit: decode, depth and program
// counter, result register. Depends on sme_pkg and sme_stack.
//
//   channel | direction | beat holds
//   --------+-----------+--------------------------------------------
//   in      | in        | mode, immediate, branch_offset
//   out     | out       | next_pc, top_value, depth, status
//
// An instruction is executed in the cycle its input beat is accepted: the
// stack cells, the depth count and the program counter all update at that
// edge, and the result is captured in the output register. One instruction
// per cycle is sustained while results are taken; the output register is
// the only stage. While a held result is not being taken, in_ready_o is
// low and a new beat waits. Reset clears the depth, the counter and the
// output valid flag; stack cells are not reset.
`default_nettype none

module stack_machine_execute_unit_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [3:0]                    mode_i,
  input  logic signed [7:0]             immediate_i,
  input  logic signed [15:0]            branch_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sme_pkg::PcW-1:0]       next_pc_o,
  output logic signed [sme_pkg::WordW-1:0] top_value_o,
  output logic [sme_pkg::DepthW-1:0]    depth_o,
  output logic [1:0]                    status_o
);
  import sme_pkg::*;

  localparam depth_t DepthFull = depth_t'(StackDepth);

  logic     fire;
  op_e      op;
  word_t    w0, w1, w2;
  stk_cmd_t cmd;

  depth_t   depth_q, depth_d;
  pc_t      pc_q, pc_d;

  logic     out_valid_q, out_valid_d;
  pc_t      out_pc_q;
  word_t    out_top_q;
  depth_t   out_depth_q;
  status_e  out_status_q;

  depth_t   need;
  logic     grow;
  logic     under, over;
  logic     taken;
  pc_t      adv;
  word_t    new_top;
  status_e  status;
  word_t    imm_word;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign op         = op_e'(mode_i);
  assign imm_word   = word_t'(immediate_i);

  sme_stack u_stack (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .word0_o (w0),
    .word1_o (w1),
    .word2_o (w2)
  );

  // How many words each instruction reads, and whether it grows the stack.
  always_comb begin
    need = '0;
    grow = 1'b0;
    unique case (op)
      OP_PUSH:                         grow = 1'b1;
      OP_ADD, OP_SUB, OP_AND, OP_OR,
      OP_SWAP, OP_IFCMPEQ:             need = depth_t'(2);
      OP_DUP: begin
        need = depth_t'(1);
        grow = 1'b1;
      end
      OP_POP, OP_IFEQ, OP_IFLT:        need = depth_t'(1);
      default: ;
    endcase
  end

  assign under = depth_q < need;
  assign over  = grow && (depth_q >= DepthFull);

  // Execute: stack movement, new depth, branch decision and new top word.
  always_comb begin
    cmd.op     = STK_HOLD;
    cmd.top_in = w0;
    depth_d    = depth_q;
    pc_d       = pc_q;
    taken      = 1'b0;
    adv        = pc_t'(1);
    new_top    = w0;
    status     = ST_OK;

    if (under) begin
      status = ST_UNDER;
    end else if (over) begin
      status = ST_OVER;
    end else begin
      unique case (op)
        OP_PUSH: begin
          cmd.op     = STK_PUSH;
          cmd.top_in = imm_word;
          new_top    = imm_word;
          depth_d    = depth_q + depth_t'(1);
          adv        = pc_t'(2);
        end
        OP_ADD, OP_SUB, OP_AND, OP_OR: begin
          unique case (op)
            OP_ADD:  cmd.top_in = w1 + w0;
            OP_SUB:  cmd.top_in = w1 - w0;
            OP_AND:  cmd.top_in = w1 & w0;
            default: cmd.top_in = w1 | w0;
          endcase
          cmd.op  = STK_REPL;
          new_top = cmd.top_in;
          depth_d = depth_q - depth_t'(1);
        end
        OP_SWAP: begin
          cmd.op  = STK_SWAP;
          new_top = w1;
        end
        OP_DUP: begin
          cmd.op  = STK_PUSH;
          depth_d = depth_q + depth_t'(1);
        end
        OP_POP: begin
          cmd.op  = STK_POP1;
          new_top = w1;
          depth_d = depth_q - depth_t'(1);
        end
        OP_GOTO: taken = 1'b1;
        OP_IFEQ, OP_IFLT: begin
          cmd.op  = STK_POP1;
          new_top = w1;
          depth_d = depth_q - depth_t'(1);
          taken   = (op == OP_IFEQ) ? (w0 == '0) : w0[WordW-1];
          adv     = pc_t'(3);
        end
        OP_IFCMPEQ: begin
          cmd.op  = STK_POP2;
          new_top = w2;
          depth_d = depth_q - depth_t'(2);
          taken   = (w0 == w1);
          adv     = pc_t'(3);
        end
        default: ;
      endcase
      pc_d = taken ? (pc_q + pc_t'(branch_offset_i)) : (pc_q + adv);
    end

    // Nothing moves unless the beat is accepted.
    if (!fire) begin
      cmd.op  = STK_HOLD;
      depth_d = depth_q;
      pc_d    = pc_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      depth_q     <= depth_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_pc_q     <= pc_d;
      out_top_q    <= (depth_d == '0) ? '0 : new_top;
      out_depth_q  <= depth_d;
      out_status_q <= status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign next_pc_o   = out_pc_q;
  assign top_value_o = out_top_q;
  assign depth_o     = out_depth_q;
  assign status_o    = out_status_q;

endmodule

`default_nettype wire

[rtl/sme_cell.sv]
// One stack cell: a word register that loads from itself or a neighbour.
// Depends on sme_pkg.
`default_nettype none

module sme_cell (
  input  logic          clk_i,
  input  sme_pkg::sel_e sel_i,
  input  sme_pkg::word_t up_i,
  input  sme_pkg::word_t dn1_i,
  input  sme_pkg::word_t dn2_i,
  output sme_pkg::word_t word_o
);
  import sme_pkg::*;

  word_t word_q, word_d;

  always_comb begin
    unique case (sel_i)
      SEL_HOLD: word_d = word_q;
      SEL_UP:   word_d = up_i;
      SEL_DN1:  word_d = dn1_i;
      SEL_DN2:  word_d = dn2_i;
      default:  word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

[rtl/sme_stack.sv]
// Row of stack cells; cell 0 is the top of stack. Each cycle every cell
// loads from itself, a near cell or top_in. Depends on sme_pkg, sme_cell.
`default_nettype none

module sme_stack (
  input  logic              clk_i,
  input  sme_pkg::stk_cmd_t cmd_i,
  output sme_pkg::word_t    word0_o,
  output sme_pkg::word_t    word1_o,
  output sme_pkg::word_t    word2_o
);
  import sme_pkg::*;

  word_t cell_word [StackDepth];

  for (genvar i = 0; i < StackDepth; i++) begin : g_cell
    sel_e  sel;
    word_t up, dn1, dn2;

    if (i == 0) begin : g_up_top
      assign up = cmd_i.top_in;
    end else begin : g_up_cell
      assign up = cell_word[i-1];
    end

    if (i + 1 < StackDepth) begin : g_dn1_cell
      assign dn1 = cell_word[i+1];
    end else begin : g_dn1_end
      assign dn1 = '0;
    end

    if (i + 2 < StackDepth) begin : g_dn2_cell
      assign dn2 = cell_word[i+2];
    end else begin : g_dn2_end
      assign dn2 = '0;
    end

    always_comb begin
      unique case (cmd_i.op)
        STK_HOLD: sel = SEL_HOLD;
        STK_PUSH: sel = SEL_UP;
        STK_POP1: sel = SEL_DN1;
        STK_POP2: sel = SEL_DN2;
        STK_REPL: sel = (i == 0) ? SEL_UP : SEL_DN1;
        STK_SWAP: sel = (i == 0) ? SEL_DN1 : ((i == 1) ? SEL_UP : SEL_HOLD);
        default:  sel = SEL_HOLD;
      endcase
    end

    // In a swap, cell 1 takes the old top word from cell 0.
    word_t up_sel;
    assign up_sel = (i == 1 && cmd_i.op == STK_SWAP) ? cell_word[0] : up;

    sme_cell u_cell (
      .clk_i  (clk_i),
      .sel_i  (sel),
      .up_i   (up_sel),
      .dn1_i  (dn1),
      .dn2_i  (dn2),
      .word_o (cell_word[i])
    );
  end

  assign word0_o = cell_word[0];
  assign word1_o = cell_word[1];
  assign word2_o = cell_word[2];

endmodule

`default_nettype wire
